// ===== hw/rtl/rcpcm_pkg.sv =====
package rcpcm_pkg;

    localparam int PULSE_W = 15;
    localparam int LEVEL_W = 16;
    // signed pulse difference, one bit wider than a pulse
    localparam int DIFF_W  = PULSE_W + 1;
    // map span is 1024 for both throttle and axis: numerator = diff << SPAN_SH
    localparam int SPAN_SH = 10;
    localparam int QUO_W   = PULSE_W + SPAN_SH;
    localparam int DVS_W   = PULSE_W;
    localparam int CNT_W   = $clog2(QUO_W + 1);
    // signed quotient plus offset, with headroom for the compare
    localparam int SUM_W   = QUO_W + 2;

    localparam int FUNC_W  = 3;
    localparam int CIDX_W  = 2;

    localparam logic [PULSE_W-1:0] RST_MIN  = PULSE_W'(2000);
    localparam logic [PULSE_W-1:0] RST_MAX  = PULSE_W'(0);
    localparam logic [PULSE_W-1:0] RST_CLOW = PULSE_W'(2000);
    localparam logic [PULSE_W-1:0] RST_CHIGH = PULSE_W'(0);

    localparam logic signed [SUM_W-1:0] AXIS_LO   = -SUM_W'(512);
    localparam logic signed [SUM_W-1:0] LEVEL_TOP = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] LEVEL_BOT = -SUM_W'(32768);

    localparam logic [LEVEL_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [LEVEL_W-1:0] SAT_NEG = 16'h8000;

    typedef enum logic [FUNC_W-1:0] {
        OP_WIDEN_ZERO = 3'd0,
        OP_WIDEN_EXT  = 3'd1,
        OP_THROTTLE   = 3'd2,
        OP_AXIS       = 3'd3,
        OP_TOGGLE     = 3'd4,
        OP_APPLY      = 3'd5
    } op_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PULSE_MIN   = 2'd0,
        CFG_PULSE_MAX   = 2'd1,
        CFG_CENTER_LOW  = 2'd2,
        CFG_CENTER_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic [QUO_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/rc_pulse_calibrate_and_map.sv =====
// RC channel calibration and linear map. Each request carries an operation code
// (s_tuser) and a pulse width in microseconds (s_tdata, 0 = timeout). The block
// keeps four bounds (pulse min/max, neutral low/high), widens them from samples,
// reloads them from the preset registers, or maps the pulse to a throttle level
// (scale 1/1024) or an axis level (scale 1/512) with truncating signed division,
// saturating to 16 bits. One request is handled at a time: s_tready is high only
// while idle. Bound updates, toggle, and map requests that fall in the neutral
// zone or hit equal extremes go from accept straight to the output state; a
// real map first waits in the divide state on the 25-step shared restoring
// divider. A finished result sits in the output register until taken, and the
// next request is accepted as soon as that register has been loaded. Preset
// writes are always accepted and take effect at the next apply request.
module rc_pulse_calibrate_and_map import rcpcm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [14:0] pulse_width, zero filled
    input  logic [FUNC_W-1:0]  s_tuser,   // [2:0] func
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] level, [16] switch_on, [17] divide_fault, [18] clipped,
    // [33:19] bound_min_now, [48:34] bound_max_now,
    // [63:49] center_low_now, [78:64] center_high_now, [79] zero
    output logic [79:0]        m_tdata,
    // preset register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [PULSE_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    state_t state_reg, state_next;

    // preset registers
    logic [PULSE_W-1:0] pre_min_reg, pre_max_reg, pre_clow_reg, pre_chigh_reg;

    // live calibration bounds
    logic [PULSE_W-1:0] bmin_reg, bmin_next;
    logic [PULSE_W-1:0] bmax_reg, bmax_next;
    logic [PULSE_W-1:0] clow_reg, clow_next;
    logic [PULSE_W-1:0] chigh_reg, chigh_next;

    // pending result
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic               sw_reg, sw_next;
    logic               fault_reg, fault_next;
    logic               clip_reg, clip_next;
    logic               neg_reg, neg_next;     // quotient sign
    logic               axis_reg, axis_next;   // add -512 after divide

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [79:0]        m_data_reg, m_data_next;

    logic               s_fire;
    logic [PULSE_W-1:0] pw;
    op_t                op;
    logic               need_map;
    logic signed [DIFF_W-1:0] diff, den;
    logic [DIFF_W-1:0]  diff_mag, den_mag;
    logic signed [SUM_W-1:0] q_signed, v_sum;
    logic               out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign pw        = s_tdata[PULSE_W-1:0];
    assign op        = op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // map numerator and denominator, both signed 16-bit
    assign diff     = $signed({1'b0, pw}) - $signed({1'b0, bmin_reg});
    assign den      = $signed({1'b0, bmax_reg}) - $signed({1'b0, bmin_reg});
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign den_mag  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

    always_comb begin
        case (op)
            OP_THROTTLE: need_map = (pw > chigh_reg);
            OP_AXIS:     need_map = !((pw >= clow_reg) && (pw <= chigh_reg));
            default:     need_map = 1'b0;
        endcase
    end

    assign div_req.start    = s_fire && need_map && (den != '0);
    assign div_req.dividend = {diff_mag[PULSE_W-1:0], {SPAN_SH{1'b0}}};
    assign div_req.divisor  = den_mag[DVS_W-1:0];

    rcpcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // signed quotient plus the low end of the output range
    assign q_signed = neg_reg ? -$signed({2'b00, div_rsp.quotient})
                              :  $signed({2'b00, div_rsp.quotient});
    assign v_sum    = q_signed + (axis_reg ? AXIS_LO : SUM_W'(0));

    always_comb begin
        state_next   = state_reg;
        bmin_next    = bmin_reg;
        bmax_next    = bmax_reg;
        clow_next    = clow_reg;
        chigh_next   = chigh_reg;
        lvl_next     = lvl_reg;
        sw_next      = sw_reg;
        fault_next   = fault_reg;
        clip_next    = clip_reg;
        neg_next     = neg_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    lvl_next   = '0;
                    sw_next    = 1'b0;
                    fault_next = 1'b0;
                    clip_next  = 1'b0;
                    neg_next   = diff[DIFF_W-1] ^ den[DIFF_W-1];
                    axis_next  = (op == OP_AXIS);
                    state_next = ST_OUTPUT;
                    case (op)
                        OP_WIDEN_ZERO: begin
                            if (pw > chigh_reg) chigh_next = pw;
                            if (pw < clow_reg)  clow_next  = pw;
                        end
                        OP_WIDEN_EXT: begin
                            if (pw > bmax_reg) bmax_next = pw;
                            if (pw < bmin_reg) bmin_next = pw;
                        end
                        OP_THROTTLE, OP_AXIS: begin
                            if (need_map) begin
                                if (den == '0) begin
                                    fault_next = 1'b1;
                                end else begin
                                    state_next = ST_DIVIDE;
                                end
                            end
                        end
                        OP_TOGGLE: begin
                            sw_next = (pw > chigh_reg);
                        end
                        OP_APPLY: begin
                            bmin_next  = pre_min_reg;
                            bmax_next  = pre_max_reg;
                            clow_next  = pre_clow_reg;
                            chigh_next = pre_chigh_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    if (v_sum > LEVEL_TOP) begin
                        lvl_next  = SAT_POS;
                        clip_next = 1'b1;
                    end else if (v_sum < LEVEL_BOT) begin
                        lvl_next  = SAT_NEG;
                        clip_next = 1'b1;
                    end else begin
                        lvl_next  = v_sum[LEVEL_W-1:0];
                    end
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, chigh_reg, clow_reg, bmax_reg, bmin_reg,
                                    clip_reg, fault_reg, sw_reg, lvl_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            bmin_reg      <= RST_MIN;
            bmax_reg      <= RST_MAX;
            clow_reg      <= RST_CLOW;
            chigh_reg     <= RST_CHIGH;
            pre_min_reg   <= RST_MIN;
            pre_max_reg   <= RST_MAX;
            pre_clow_reg  <= RST_CLOW;
            pre_chigh_reg <= RST_CHIGH;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bmin_reg    <= bmin_next;
            bmax_reg    <= bmax_next;
            clow_reg    <= clow_next;
            chigh_reg   <= chigh_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PULSE_MIN:   pre_min_reg   <= cfg_data;
                    CFG_PULSE_MAX:   pre_max_reg   <= cfg_data;
                    CFG_CENTER_LOW:  pre_clow_reg  <= cfg_data;
                    CFG_CENTER_HIGH: pre_chigh_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        // payload, no reset needed
        lvl_reg    <= lvl_next;
        sw_reg     <= sw_next;
        fault_reg  <= fault_next;
        clip_reg   <= clip_next;
        neg_reg    <= neg_next;
        axis_reg   <= axis_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/rcpcm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rcpcm_div import rcpcm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W+1:0] trial;

    assign trial = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[DVS_W+1]) begin
                rem_next = {rem_reg[DVS_W-2:0], quo_reg[QUO_W-1]};
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench import rcpcm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Codes and map constants
    // ------------------------------------------------------------------
    // func codes past apply are decoded as no-ops by the block
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

    localparam longint MAP_SPAN    = 1024;   // out_hi - out_lo, throttle and axis alike
    localparam longint THR_OFFSET  = 0;
    localparam longint AXIS_OFFSET = -512;
    localparam longint LEVEL_MAX   = 32767;
    localparam longint LEVEL_MIN   = -32768;
    localparam int     PULSE_TOP   = 25000;
    localparam int     DRAIN_CYCLES = 40;    // longer than a real map takes

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [PULSE_W-1:0] pulse;
    } pulse_req_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      switch_on;
        logic                      div_fault;
        logic                      clipped;
        logic [PULSE_W-1:0]        lo_now;
        logic [PULSE_W-1:0]        hi_now;
        logic [PULSE_W-1:0]        band_lo_now;
        logic [PULSE_W-1:0]        band_hi_now;
    } channel_result_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata   = '0;   // [14:0] pulse_width, [15] zero
    logic [FUNC_W-1:0]  s_tuser   = '0;   // [2:0] func
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [79:0]        m_tdata;          // level, flags, four bounds; see RTL header
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [PULSE_W-1:0] cfg_data  = '0;

    always #5 aclk = ~aclk;

    rc_pulse_calibrate_and_map uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the channel: presets and live calibration bounds
    // ------------------------------------------------------------------
    logic [PULSE_W-1:0] preset_lo      = RST_MIN;
    logic [PULSE_W-1:0] preset_hi      = RST_MAX;
    logic [PULSE_W-1:0] preset_band_lo = RST_CLOW;
    logic [PULSE_W-1:0] preset_band_hi = RST_CHIGH;

    logic [PULSE_W-1:0] pulse_lo = RST_MIN;   // smallest pulse seen
    logic [PULSE_W-1:0] pulse_hi = RST_MAX;   // largest pulse seen
    logic [PULSE_W-1:0] band_lo  = RST_CLOW;  // neutral band edges
    logic [PULSE_W-1:0] band_hi  = RST_CHIGH;

    pulse_req_t      request_q[$];     // requests waiting for the driver
    channel_result_t level_expect_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int n_results     = 0;
    int n_queued      = 0;             // every request pushed, spare codes included

    // Linear map against the live extremes, truncating division, 16-bit saturate.
    function automatic void map_pulse(input logic [PULSE_W-1:0] x, input longint offset,
                                      inout channel_result_t res);
        longint span_den;
        longint mapped;
        span_den = longint'(pulse_hi) - longint'(pulse_lo);
        if (span_den == 0) begin
            res.div_fault = 1'b1;   // equal extremes: level stays 0
        end else begin
            mapped = (longint'(x) - longint'(pulse_lo)) * MAP_SPAN / span_den + offset;
            if (mapped > LEVEL_MAX) begin
                res.level   = 16'(LEVEL_MAX);
                res.clipped = 1'b1;
            end else if (mapped < LEVEL_MIN) begin
                res.level   = 16'(LEVEL_MIN);
                res.clipped = 1'b1;
            end else begin
                res.level = 16'(mapped);
            end
        end
    endfunction

    // Advance the shadow by one accepted request and queue what the block must return.
    function automatic void predict_channel(input pulse_req_t r);
        channel_result_t res = '0;
        case (r.func)
            OP_WIDEN_ZERO: begin
                if (r.pulse > band_hi) band_hi = r.pulse;
                if (r.pulse < band_lo) band_lo = r.pulse;
            end
            OP_WIDEN_EXT: begin
                if (r.pulse > pulse_hi) pulse_hi = r.pulse;
                if (r.pulse < pulse_lo) pulse_lo = r.pulse;
            end
            OP_THROTTLE: begin
                // at or below the band top reads as zero throttle
                if (r.pulse > band_hi) map_pulse(r.pulse, THR_OFFSET, res);
            end
            OP_AXIS: begin
                // inside the neutral band reads as centered
                if (r.pulse < band_lo || r.pulse > band_hi) map_pulse(r.pulse, AXIS_OFFSET, res);
            end
            OP_TOGGLE: res.switch_on = (r.pulse > band_hi);
            OP_APPLY: begin
                pulse_lo = preset_lo;
                pulse_hi = preset_hi;
                band_lo  = preset_band_lo;
                band_hi  = preset_band_hi;
            end
            default: ;   // spare codes: no state change, all zero
        endcase
        res.lo_now      = pulse_lo;
        res.hi_now      = pulse_hi;
        res.band_lo_now = band_lo;
        res.band_hi_now = band_hi;
        level_expect_q.push_back(res);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      n_results, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request driver: presents request_q[0], predicts on accept
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            predict_channel(request_q[0]);
            void'(request_q.pop_front());
        end
        // only touch the bus when nothing is stuck waiting for tready
        if (!s_tvalid || s_tready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= request_q[0].func;
                s_tdata  <= {1'b0, request_q[0].pulse};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        channel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (level_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          n_results));
            end else begin
                want = level_expect_q.pop_front();
                check_field("level", $signed(m_tdata[15:0]), want.level);
                check_field("switch_on", m_tdata[16], want.switch_on);
                check_field("divide_fault", m_tdata[17], want.div_fault);
                check_field("clipped", m_tdata[18], want.clipped);
                check_field("bound_min_now", m_tdata[33:19], want.lo_now);
                check_field("bound_max_now", m_tdata[48:34], want.hi_now);
                check_field("center_low_now", m_tdata[63:49], want.band_lo_now);
                check_field("center_high_now", m_tdata[78:64], want.band_hi_now);
            end
            n_results++;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input logic [FUNC_W-1:0] func, input int pulse);
        pulse_req_t r;
        r.func  = func;
        r.pulse = PULSE_W'(pulse);
        request_q.push_back(r);
        n_queued++;
    endtask

    // block until every queued request was taken and answered
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || level_expect_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_preset(input cfg_idx_t idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= PULSE_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PULSE_MIN:   preset_lo      = PULSE_W'(value);
            CFG_PULSE_MAX:   preset_hi      = PULSE_W'(value);
            CFG_CENTER_LOW:  preset_band_lo = PULSE_W'(value);
            CFG_CENTER_HIGH: preset_band_hi = PULSE_W'(value);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // presets only change while the channel is idle
    task automatic load_presets(input int lo, input int hi, input int blo, input int bhi);
        wait_drained();
        write_preset(CFG_PULSE_MIN, lo);
        write_preset(CFG_PULSE_MAX, hi);
        write_preset(CFG_CENTER_LOW, blo);
        write_preset(CFG_CENTER_HIGH, bhi);
    endtask

    function automatic int rand_pulse();
        int unsigned sel = $urandom_range(99);
        if (sel < 70) return $urandom_range(2200, 800);   // realistic servo range
        if (sel < 76) return 0;                           // timeout
        return $urandom_range(PULSE_TOP);
    endfunction

    // Mixed traffic, weighted toward the mapping operations.
    task automatic push_random_req();
        int unsigned sel = $urandom_range(99);
        logic [FUNC_W-1:0] func;
        if      (sel < 10) func = OP_WIDEN_ZERO;
        else if (sel < 20) func = OP_WIDEN_EXT;
        else if (sel < 46) func = OP_THROTTLE;
        else if (sel < 72) func = OP_AXIS;
        else if (sel < 88) func = OP_TOGGLE;
        else if (sel < 94) func = OP_APPLY;
        else               func = ($urandom_range(1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
        push_req(func, rand_pulse());
    endtask

    // One calibration pass as a user would do it, then free use of the stick.
    task automatic push_session();
        push_req(OP_APPLY, $urandom_range(PULSE_TOP));
        repeat ($urandom_range(6, 2)) push_req(OP_WIDEN_ZERO, $urandom_range(1600, 1400));
        repeat ($urandom_range(6, 2)) begin
            if ($urandom_range(1) != 0) push_req(OP_WIDEN_EXT, $urandom_range(1100, 850));
            else                        push_req(OP_WIDEN_EXT, $urandom_range(2150, 1900));
        end
        repeat ($urandom_range(40, 20)) push_random_req();
    endtask

    task automatic run_phase(input int target, input bit pause_mid);
        int  start_cnt = n_queued;
        bit  paused    = 1'b0;
        while (n_queued - start_cnt < target) begin
            push_session();
            // sender holds off until the block has answered everything
            if (pause_mid && !paused && n_queued - start_cnt >= target / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 46;

        // Directed: reset bounds are reversed (min 2000, max 0), band empty
        push_req(OP_THROTTLE, 1000);
        push_req(OP_AXIS, 0);              // empty band, timeout pulse still maps
        push_req(OP_TOGGLE, 0);
        push_req(OP_TOGGLE, PULSE_TOP);
        push_req(FUNC_SPARE_A, PULSE_TOP);
        push_req(FUNC_SPARE_B, 0);
        push_req(OP_WIDEN_EXT, 0);         // timeout drags the floor to 0
        push_req(OP_WIDEN_EXT, PULSE_TOP);
        push_req(OP_THROTTLE, PULSE_TOP);
        push_req(OP_THROTTLE, 0);          // at band top: zero throttle
        push_req(OP_WIDEN_ZERO, 1400);
        push_req(OP_WIDEN_ZERO, 1600);
        push_req(OP_AXIS, 1500);           // centered
        push_req(OP_AXIS, 1000);
        push_req(OP_THROTTLE, 1600);       // edge of band, still zero
        push_req(OP_THROTTLE, 1601);
        push_req(OP_TOGGLE, 1600);
        push_req(OP_APPLY, 0);             // back to reset presets

        // equal extremes: every request that needs a map faults
        load_presets(1500, 1500, 1400, 1600);
        push_req(OP_APPLY, 0);
        push_req(OP_THROTTLE, 2000);
        push_req(OP_AXIS, 1000);
        push_req(OP_AXIS, 1400);           // lower band edge is neutral

        // one-count span: positive saturation
        load_presets(0, 1, 0, 0);
        push_req(OP_APPLY, 0);
        push_req(OP_THROTTLE, PULSE_TOP);
        push_req(OP_AXIS, PULSE_TOP);

        // floor far above sample: negative saturation
        load_presets(24999, PULSE_TOP, PULSE_TOP, PULSE_TOP);
        push_req(OP_APPLY, 0);
        push_req(OP_AXIS, 0);
        push_req(OP_TOGGLE, PULSE_TOP);

        // Random phase 1: typical servo presets, mid-phase drain
        load_presets($urandom_range(1050, 950), $urandom_range(2050, 1950),
                     $urandom_range(1490, 1450), $urandom_range(1550, 1510));
        run_phase(440, 1'b1);

        // Random phase 2: presets anywhere in range, idling swapped
        wait_drained();
        send_idle_pct = 46;
        recv_idle_pct = 31;
        load_presets($urandom_range(PULSE_TOP), $urandom_range(PULSE_TOP),
                     $urandom_range(PULSE_TOP), $urandom_range(PULSE_TOP));
        run_phase(440, 1'b0);

        // Random phase 3: full-scale extremes, inverted band, no idling
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_presets(0, PULSE_TOP, PULSE_TOP, 0);
        run_phase(440, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("rc_pulse_calibrate_and_map regression: pass");
        end else begin
            $display("rc_pulse_calibrate_and_map regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("rc_pulse_calibrate_and_map regression: fail");
        $finish;
    end

endmodule
